// ===== rtl/core/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the report segmenter: transaction structs,
// command and status codes, report framing bytes and the job descriptor.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int LEN_W        = 8;
    localparam int REPORT_BYTES = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 6;
    localparam int OFF_W        = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PREPARE = 2'd1;
    localparam logic [1:0] CMD_COMMIT  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BYTE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Report framing
    localparam logic [7:0] RPT_PREFIX    = 8'hff;
    localparam logic [7:0] FORM_SINGLE   = 8'h10;
    localparam logic [7:0] FORM_FIRST    = 8'h11;
    localparam logic [7:0] FORM_CONTINUE = 8'h12;
    localparam logic [7:0] FORM_FINAL    = 8'h13;
    localparam logic [7:0] CAP_SINGLE    = 8'd62;
    localparam logic [7:0] CAP_FIRST     = 8'd60;
    localparam logic [7:0] CAP_CONTINUE  = 8'd61;
    localparam logic [OFF_W-1:0] OFF_SINGLE   = 3'd2;
    localparam logic [OFF_W-1:0] OFF_FIRST    = 3'd4;
    localparam logic [OFF_W-1:0] OFF_CONTINUE = 3'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_byte;
    } request_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       report_last;
        logic [1:0] status;
    } result_t;

    // Work item handed from the front to the back
    typedef struct packed {
        logic             is_report;
        logic [1:0]       status;
        logic [7:0]       form;
        logic [7:0]       hdr2;
        logic [7:0]       hdr3;
        logic [LEN_W-1:0] start;
        logic [OFF_W-1:0] offset;
        logic [CNT_W-1:0] count;
    } job_t;

endpackage

// ===== rtl/core/rsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 255,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rsc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_queue
// Short job queue between the command front end and the result back end.
// ----------------------------------------------------------------------------
module rsc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsc_pkg::job_t push_job,
    input  logic          pop,
    output rsc_pkg::job_t head,
    output logic          empty,
    output logic          full
);

    rsc_pkg::job_t                entries [rsc_pkg::QUEUE_DEPTH];
    logic [rsc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rsc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rsc_pkg::QPTR_W:0]     count_reg;
    logic [rsc_pkg::QPTR_W:0]     count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (rsc_pkg::QPTR_W + 1)'(rsc_pkg::QUEUE_DEPTH));
    assign head  = entries[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("rsc_queue: pop while empty");
`endif

endmodule

// ===== rtl/core/rsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_front
// Command front end: holds the message state, writes payload bytes, and
// turns every accepted transaction into one job for the back end.
// ----------------------------------------------------------------------------
module rsc_front #(
    parameter int MAX_PAYLOAD = 255,
    parameter int ADDR_W      = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsc_pkg::request_t request,
    output logic              push,
    output rsc_pkg::job_t     push_job,
    input  logic              queue_full,
    input  logic              report_done,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata
);

    localparam logic [rsc_pkg::LEN_W-1:0] MAX_LEN = rsc_pkg::LEN_W'(MAX_PAYLOAD);

    logic [rsc_pkg::LEN_W-1:0] msg_len_reg,  msg_len_next;
    logic [rsc_pkg::LEN_W-1:0] load_cnt_reg, load_cnt_next;
    logic [rsc_pkg::LEN_W-1:0] cursor_reg,   cursor_next;
    logic [rsc_pkg::LEN_W-1:0] seq_reg,      seq_next;
    logic                      prepared_reg, prepared_next;
    logic [rsc_pkg::CNT_W-1:0] prep_cnt_reg, prep_cnt_next;
    logic                      rpt_pend_reg, rpt_pend_next;

    logic                      accept;
    logic [rsc_pkg::LEN_W-1:0] remaining;
    logic [rsc_pkg::LEN_W-1:0] load_inc;
    logic [rsc_pkg::LEN_W:0]   commit_sum;
    logic [rsc_pkg::LEN_W-1:0] take;

    assign accept    = start && !busy;
    assign busy      = queue_full || rpt_pend_reg;
    assign remaining = msg_len_reg - cursor_reg;
    assign load_inc  = load_cnt_reg + 1'b1;
    assign commit_sum = {1'b0, cursor_reg} + {3'b000, prep_cnt_reg};
    assign ram_waddr = load_cnt_reg[ADDR_W-1:0];
    assign ram_wdata = request.data_byte;

    // Decode the transaction and build its job
    always_comb
    begin
        msg_len_next  = msg_len_reg;
        load_cnt_next = load_cnt_reg;
        cursor_next   = cursor_reg;
        seq_next      = seq_reg;
        prepared_next = prepared_reg;
        prep_cnt_next = prep_cnt_reg;
        rpt_pend_next = rpt_pend_reg && !report_done;
        ram_we        = 1'b0;
        push          = accept;
        push_job      = '0;
        push_job.status = rsc_pkg::ST_REJECT;
        take          = '0;

        if (accept)
        begin
            case (request.command)
                rsc_pkg::CMD_LOAD:
                begin
                    if (msg_len_reg != '0 || prepared_reg)
                    begin
                        push_job.status = rsc_pkg::ST_REJECT;
                    end
                    else if (load_cnt_reg >= MAX_LEN)
                    begin
                        load_cnt_next   = '0;
                        push_job.status = rsc_pkg::ST_REJECT;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        load_cnt_next   = load_inc;
                        push_job.status = rsc_pkg::ST_DONE;
                        if (request.last_byte)
                        begin
                            msg_len_next  = load_inc;
                            load_cnt_next = '0;
                            cursor_next   = '0;
                            seq_next      = '0;
                        end
                    end
                end
                rsc_pkg::CMD_PREPARE:
                begin
                    if (cursor_reg < msg_len_reg)
                    begin
                        push_job.is_report = 1'b1;
                        push_job.status    = rsc_pkg::ST_BYTE;
                        if (cursor_reg == '0 && msg_len_reg <= rsc_pkg::CAP_SINGLE)
                        begin
                            push_job.form   = rsc_pkg::FORM_SINGLE;
                            push_job.offset = rsc_pkg::OFF_SINGLE;
                            push_job.start  = '0;
                            take            = remaining;
                        end
                        else if (cursor_reg == '0)
                        begin
                            push_job.form   = rsc_pkg::FORM_FIRST;
                            push_job.hdr3   = msg_len_reg;
                            push_job.offset = rsc_pkg::OFF_FIRST;
                            push_job.start  = '0;
                            take = (remaining < rsc_pkg::CAP_FIRST) ? remaining
                                                                    : rsc_pkg::CAP_FIRST;
                        end
                        else
                        begin
                            push_job.form   = (remaining <= rsc_pkg::CAP_CONTINUE)
                                              ? rsc_pkg::FORM_FINAL
                                              : rsc_pkg::FORM_CONTINUE;
                            push_job.hdr2   = seq_reg;
                            push_job.offset = rsc_pkg::OFF_CONTINUE;
                            push_job.start  = cursor_reg;
                            take = (remaining < rsc_pkg::CAP_CONTINUE) ? remaining
                                                                       : rsc_pkg::CAP_CONTINUE;
                        end
                        push_job.count = take[rsc_pkg::CNT_W-1:0];
                        prep_cnt_next  = take[rsc_pkg::CNT_W-1:0];
                        prepared_next  = 1'b1;
                        rpt_pend_next  = 1'b1;
                    end
                    else
                    begin
                        push_job.status = rsc_pkg::ST_REJECT;
                    end
                end
                rsc_pkg::CMD_COMMIT:
                begin
                    if (prepared_reg)
                    begin
                        push_job.status = rsc_pkg::ST_DONE;
                        cursor_next     = commit_sum[rsc_pkg::LEN_W-1:0];
                        if (cursor_reg == '0 && msg_len_reg > rsc_pkg::CAP_SINGLE)
                        begin
                            seq_next = 8'd1;
                        end
                        else
                        begin
                            seq_next = seq_reg + 1'b1;
                        end
                        prep_cnt_next = '0;
                        prepared_next = 1'b0;
                        if (commit_sum >= {1'b0, msg_len_reg})
                        begin
                            msg_len_next = '0;
                            cursor_next  = '0;
                            seq_next     = '0;
                        end
                    end
                    else
                    begin
                        push_job.status = rsc_pkg::ST_REJECT;
                    end
                end
                default:
                begin
                    push_job.status = rsc_pkg::ST_REJECT;
                end
            endcase
        end
    end

    // Hold message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg  <= '0;
            load_cnt_reg <= '0;
            cursor_reg   <= '0;
            seq_reg      <= '0;
            prepared_reg <= 1'b0;
            prep_cnt_reg <= '0;
            rpt_pend_reg <= 1'b0;
        end
        else
        begin
            msg_len_reg  <= msg_len_next;
            load_cnt_reg <= load_cnt_next;
            cursor_reg   <= cursor_next;
            seq_reg      <= seq_next;
            prepared_reg <= prepared_next;
            prep_cnt_reg <= prep_cnt_next;
            rpt_pend_reg <= rpt_pend_next;
        end
    end

`ifndef SYNTHESIS
    // A prepared report always belongs to a pending message
    assert property (@(posedge clk) disable iff (!rst_n)
        prepared_reg |-> (msg_len_reg != '0))
        else $error("rsc_front: report prepared without a message");

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("rsc_front: queue overflow");

    // Payload writes only while no report is streaming and no message pending
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!rpt_pend_reg && msg_len_reg == '0 && !prepared_reg))
        else $error("rsc_front: payload write while busy");
`endif

endmodule

// ===== rtl/core/rsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_back
// Result back end: takes jobs from the queue and emits either one status
// result or a 64-byte report, reading payload bytes from the store.
// ----------------------------------------------------------------------------
module rsc_back #(
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_pkg::job_t     head,
    input  logic              queue_empty,
    output logic              pop,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [7:0]        ram_rdata,
    output logic              report_done,
    output logic              result_valid,
    output rsc_pkg::result_t  result
);

    localparam logic [rsc_pkg::IDX_W-1:0] LAST_IDX = rsc_pkg::IDX_W'(rsc_pkg::REPORT_BYTES - 1);

    rsc_pkg::job_t              job_reg;
    logic                       active_reg;
    logic [rsc_pkg::IDX_W-1:0]  idx_reg;

    logic                       s1_valid_reg;
    logic                       s1_use_ram_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_last_reg;
    logic [1:0]                 s1_status_reg;

    logic                       elem_last;
    logic [rsc_pkg::IDX_W:0]    rel;
    logic                       past_hdr;
    logic                       in_pay;
    logic [rsc_pkg::LEN_W-1:0]  addr;
    logic [7:0]                 elem_byte;

    assign elem_last = job_reg.is_report ? (idx_reg == LAST_IDX) : 1'b1;
    assign pop       = !queue_empty && (!active_reg || elem_last);

    // Locate the payload byte for the current report position
    assign rel      = {1'b0, idx_reg} - {4'b0000, job_reg.offset};
    assign past_hdr = (idx_reg >= {3'b000, job_reg.offset});
    assign in_pay   = past_hdr && (rel[rsc_pkg::IDX_W-1:0] < job_reg.count);
    assign addr     = job_reg.start + {2'b00, rel[rsc_pkg::IDX_W-1:0]};
    assign ram_raddr = addr[ADDR_W-1:0];

    // Select header or fill byte
    always_comb
    begin
        elem_byte = 8'h00;
        if (job_reg.is_report && !past_hdr)
        begin
            case (idx_reg)
                6'd0:    elem_byte = rsc_pkg::RPT_PREFIX;
                6'd1:    elem_byte = job_reg.form;
                6'd2:    elem_byte = job_reg.hdr2;
                6'd3:    elem_byte = job_reg.hdr3;
                default: elem_byte = 8'h00;
            endcase
        end
    end

    // Hold the current job
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
    end

    // Advance the element counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (active_reg && elem_last)
        begin
            active_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Register the element alongside the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_use_ram_reg <= job_reg.is_report && in_pay;
        s1_byte_reg    <= elem_byte;
        s1_last_reg    <= elem_last;
        s1_status_reg  <= job_reg.status;
    end

    // Drive the result transaction
    assign result_valid       = s1_valid_reg;
    assign result.report_byte = s1_use_ram_reg ? ram_rdata : s1_byte_reg;
    assign result.report_last = s1_last_reg;
    assign result.status      = s1_status_reg;
    assign report_done = s1_valid_reg && s1_last_reg && (s1_status_reg == rsc_pkg::ST_BYTE);

`ifndef SYNTHESIS
    // A status result always closes its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != rsc_pkg::ST_BYTE) |-> result.report_last)
        else $error("rsc_back: status result not marked last");
`endif

endmodule

// ===== rtl/core/report_segmenter_with_commit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// report_segmenter_with_commit
// Loads a message byte by byte and cuts it into 64-byte framed reports that
// are sent on prepare and retired on commit.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   request carries command (load, prepare, commit), data_byte, last_byte.
//   Each result sits on result for one cycle with result_valid high; the
//   receiver cannot stall, so results are never held back.
//   Load, commit, rejected commands: one status result, passed through the
//   job queue, the back end's job register and its output register; one
//   may be accepted every cycle while the two-entry job queue has room
//   and no report is pending. Accepted prepare: 64 report bytes, one per
//   cycle, through those registers. busy stays high until the last byte
//   leaves; the one-byte-per-cycle read port of the payload store sets
//   the streaming rate.
//   Reset clears all message state and the queue; the payload store is not
//   cleared and is valid only where the current message wrote it.
// ----------------------------------------------------------------------------
module report_segmenter_with_commit #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsc_pkg::request_t request,
    output logic              result_valid,
    output rsc_pkg::result_t  result
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              push;
    rsc_pkg::job_t     push_job;
    logic              pop;
    rsc_pkg::job_t     head;
    logic              queue_empty;
    logic              queue_full;
    logic              report_done;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    rsc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .push        (push),
        .push_job    (push_job),
        .queue_full  (queue_full),
        .report_done (report_done),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata)
    );

    rsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    rsc_ram #(
        .WIDTH  (8),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rsc_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .report_done  (report_done),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
